### sv/ttl_pkg.sv
// Shared package for the TTL key-value table: operation and status codes,
// the table entry layout and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package ttl_pkg;

  localparam int DEFAULT_ENTRIES = 16;

  localparam logic [2:0] OP_GET = 3'd0;
  localparam logic [2:0] OP_SET = 3'd1;
  localparam logic [2:0] OP_DEL = 3'd2;
  localparam logic [2:0] OP_INC = 3'd3;
  localparam logic [2:0] OP_DEC = 3'd4;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // One table slot as it is kept in the entry memory.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] expiry;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cnt_clr;
    logic cnt_inc;
    logic clear_wr;
    logic scan_rd;
    logic load_req;
    logic write_back;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } dp_status_t;

  function automatic int addr_bits(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

### sv/ttl_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module ttl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [ttl_pkg::addr_bits(DEPTH)-1:0]  wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [ttl_pkg::addr_bits(DEPTH)-1:0]  rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### sv/ttl_datapath.sv
// Datapath of the TTL key-value table: request registers, slot counter,
// entry memory, scan evaluation, write-back and the output register.
// Depends on ttl_pkg and ttl_ram.
`default_nettype none

module ttl_datapath #(
  parameter int TABLE_ENTRIES = ttl_pkg::DEFAULT_ENTRIES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ttl_pkg::ctl_cmd_t   cmd,
  output ttl_pkg::dp_status_t      sts,
  input  wire logic [2:0]          operation,
  input  wire logic [31:0]         current_time,
  input  wire logic signed [31:0]  key,
  input  wire logic signed [31:0]  value_or_delta,
  input  wire logic signed [31:0]  ttl,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               status,
  output logic signed [31:0]       value
);

  localparam int AW = ttl_pkg::addr_bits(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  logic [2:0]  req_op;
  logic [31:0] req_time;
  logic [31:0] req_key;
  logic [31:0] req_val;
  logic [31:0] req_ttl;

  logic [AW-1:0] addr;
  logic          rd_valid_q;
  logic [AW-1:0] rd_addr_q;

  logic          found;
  logic [AW-1:0] found_addr;
  logic [31:0]   found_value;
  logic [31:0]   found_expiry;
  logic          free_found;
  logic [AW-1:0] free_addr;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  ttl_pkg::entry_t          wr_entry;
  logic [$bits(ttl_pkg::entry_t)-1:0] rd_data;
  ttl_pkg::entry_t          rd_entry;

  logic        live;
  logic        hit;
  logic        vacant;
  logic        ttl_pos;
  logic [32:0] expiry_sum;
  logic [31:0] set_expiry;
  logic [31:0] upd_value;

  logic            wb_en;
  logic [AW-1:0]   wb_addr;
  ttl_pkg::entry_t wb_entry;
  logic [1:0]      res_status;
  logic [31:0]     res_value;

  ttl_ram #(
    .WIDTH($bits(ttl_pkg::entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (cmd.scan_rd),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op   <= operation;
      req_time <= current_time;
      req_key  <= key;
      req_val  <= value_or_delta;
      req_ttl  <= ttl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        addr <= '0;
      end else if (cmd.cnt_inc) begin
        addr <= addr + AW'(1);
      end
      rd_valid_q <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= addr;
  end

  // Entry evaluation on the read data of the previous scan cycle.
  assign rd_entry = ttl_pkg::entry_t'(rd_data);
  assign live     = rd_entry.valid &&
                    (rd_entry.expiry == 32'd0 || rd_entry.expiry >= req_time);
  assign hit      = rd_valid_q && live && (rd_entry.key == req_key);
  assign vacant   = rd_valid_q && !live;

  // The first live match and the first slot that is not live are kept.
  always_ff @(posedge clk) begin
    if (rst || cmd.load_req) begin
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (hit && !found) begin
        found <= 1'b1;
      end
      if (vacant && !free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit && !found) begin
      found_addr   <= rd_addr_q;
      found_value  <= rd_entry.value;
      found_expiry <= rd_entry.expiry;
    end
    if (vacant && !free_found) begin
      free_addr <= rd_addr_q;
    end
  end

  // Expiry is time + ttl - 1, saturated; a ttl of zero or less never expires.
  assign ttl_pos    = !req_ttl[31] && (req_ttl != 32'd0);
  assign expiry_sum = {1'b0, req_time} + {1'b0, req_ttl - 32'd1};
  always_comb begin
    if (!ttl_pos) begin
      set_expiry = 32'd0;
    end else if (expiry_sum[32]) begin
      set_expiry = '1;
    end else begin
      set_expiry = expiry_sum[31:0];
    end
  end

  assign upd_value = (req_op == ttl_pkg::OP_INC) ? found_value + req_val
                                                 : found_value - req_val;

  always_comb begin
    wb_en      = 1'b0;
    wb_addr    = found_addr;
    wb_entry   = '{valid: 1'b1, key: req_key, value: req_val, expiry: set_expiry};
    res_status = ttl_pkg::ST_MISSING;
    res_value  = 32'd0;
    unique case (req_op)
      ttl_pkg::OP_GET: begin
        if (found) begin
          res_status = ttl_pkg::ST_FOUND;
          res_value  = found_value;
        end
      end
      ttl_pkg::OP_SET: begin
        if (found || free_found) begin
          wb_en      = 1'b1;
          wb_addr    = found ? found_addr : free_addr;
          res_status = ttl_pkg::ST_DONE;
          res_value  = req_val;
        end else begin
          res_status = ttl_pkg::ST_FULL;
        end
      end
      ttl_pkg::OP_DEL: begin
        if (found) begin
          res_status = ttl_pkg::ST_DONE;
        end
      end
      ttl_pkg::OP_INC, ttl_pkg::OP_DEC: begin
        if (found) begin
          wb_en      = 1'b1;
          wb_entry   = '{valid: 1'b1, key: req_key, value: upd_value,
                         expiry: found_expiry};
          res_status = ttl_pkg::ST_FOUND;
          res_value  = upd_value;
        end
      end
      default: begin
        res_status = ttl_pkg::ST_MISSING;
      end
    endcase
  end

  // Memory write port: clearing pass, delete during the scan, write-back.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = addr;
    wr_entry = '0;
    priority if (cmd.clear_wr) begin
      wr_en = 1'b1;
    end else if (hit && req_op == ttl_pkg::OP_DEL) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr_q;
    end else if (cmd.write_back && wb_en) begin
      wr_en    = 1'b1;
      wr_addr  = wb_addr;
      wr_entry = wb_entry;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= res_status;
      value  <= res_value;
    end
  end

  assign sts.cnt_last = (addr == LAST_ADDR);
  assign sts.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

### sv/ttl_controller.sv
// Controller state machine of the TTL key-value table: clearing pass,
// request intake, slot scan, write-back and result hand-off.
// Depends on ttl_pkg.
`default_nettype none

module ttl_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ttl_pkg::dp_status_t  sts,
  output ttl_pkg::ctl_cmd_t         cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_back = 1'b1;
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

`ifndef SYNTH
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid) |=> (state == S_SCAN))
    else $error("accepted request did not start a scan");

  a_scan_ends_in_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sts.cnt_last) |=> (state == S_DRAIN && !cmd.scan_rd))
    else $error("scan did not stop after the last slot");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (sts.out_free && (state == S_WRITE || state == S_DONE)))
    else $error("result loaded while the output register was occupied");

  a_write_back_once: assert property (@(posedge clk) disable iff (rst)
    cmd.write_back |=> !cmd.write_back)
    else $error("write-back issued twice for one request");
`endif

endmodule

`default_nettype wire

### sv/ttl_key_value_table.sv
// Flow: a request accepted in the idle state scans every slot, passes the drain state and
// loads its result in the write-back state, or waits in the done state while the output
// register is occupied. Requests are taken one at a time, as each scan walks the single
// read port of the entry memory one slot per cycle. Reset: synchronous, active high;
// afterward a clearing pass marks every slot empty, and no request is taken until it ends.
`default_nettype none

// The table keeps TABLE_ENTRIES slots in one memory, each slot holding a
// valid flag, key, value and expiry time. Every request first scans all
// slots in order. During the scan the datapath remembers the lowest slot
// that is live and matches the key, and the lowest slot that is not live.
// A slot is live while it is valid and its expiry is zero or not below the
// request's time, so expiry is checked lazily and stale slots are reused.
//
// Delete clears every live match while the scan passes over it. Set,
// increment and decrement write the chosen slot back after the scan, and
// the result beat then goes into an output register, so the next
// request can be taken while that beat still waits for the consumer.
//
// The controller and the datapath are separate modules; they talk only
// through a command struct and a status struct.

module ttl_key_value_table #(
  parameter int TABLE_ENTRIES = ttl_pkg::DEFAULT_ENTRIES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         operation,
  input  wire logic [31:0]        current_time,
  input  wire logic signed [31:0] key,
  input  wire logic signed [31:0] value_or_delta,
  input  wire logic signed [31:0] ttl,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic signed [31:0]      value
);

  ttl_pkg::ctl_cmd_t   cmd;
  ttl_pkg::dp_status_t sts;

  // Sequencing: clearing pass, intake, scan, write-back, result hand-off.
  ttl_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Request registers, entry memory, slot evaluation and output register.
  ttl_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (operation),
    .current_time   (current_time),
    .key            (key),
    .value_or_delta (value_or_delta),
    .ttl            (ttl),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .value          (value)
  );

endmodule

`default_nettype wire

### sim/ttl_key_value_table_tb.sv
// Self-checking testbench for the TTL key-value table: directed and random requests
// are checked against a behavioral copy of the table kept in this file.
// Depends on ttl_pkg for the operation and status codes and on the RTL top level.
`timescale 1ns / 100ps

module ttl_key_value_table_tb;

  localparam int          TABLE_ENTRIES = ttl_pkg::DEFAULT_ENTRIES;
  // Operation codes the block does not define; they must act as a miss.
  localparam logic [2:0]  OP_SPARE_LO   = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI   = 3'd7;
  localparam logic [31:0] INT_MAX       = 32'h7FFF_FFFF;
  localparam logic [31:0] INT_MIN       = 32'h8000_0000;
  localparam logic [31:0] TIME_MAX      = 32'hFFFF_FFFF;
  localparam int          KEY_POOL_SIZE = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } response_t;

  // Every input starts at a known value; rst is held from time zero.
  logic               clk;
  logic               rst            = 1'b1;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [2:0]         operation      = 3'd0;
  logic [31:0]        current_time   = 32'd0;
  logic signed [31:0] key            = 32'sd0;
  logic signed [31:0] value_or_delta = 32'sd0;
  logic signed [31:0] ttl            = 32'sd0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] value;

  ttl_key_value_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .current_time  (current_time),
    .key           (key),
    .value_or_delta(value_or_delta),
    .ttl           (ttl),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .value         (value)
  );

  // Our own copy of the table. Slots are only looked at while marked valid.
  logic        slot_valid  [TABLE_ENTRIES];
  logic [31:0] slot_key    [TABLE_ENTRIES];
  logic [31:0] slot_value  [TABLE_ENTRIES];
  logic [31:0] slot_expiry [TABLE_ENTRIES];

  // Responses predicted at request acceptance, oldest at the front.
  response_t   awaited_responses[$];
  response_t   oldest_response;

  logic [31:0] key_pool[KEY_POOL_SIZE];
  logic [31:0] sim_now       = 32'd0;
  int unsigned mismatches    = 0;
  int unsigned requests_sent = 0;
  int unsigned responses_ok  = 0;
  int unsigned status_tally[4];
  int unsigned gap_odds      = 20;
  // Once set, neither side inserts idle cycles any more.
  bit          calm          = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #5_000_000;
    $display("Timeout with %0d responses still outstanding", awaited_responses.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // A slot is live while valid and either never expiring or not yet past its expiry.
  function automatic bit is_live(input int idx, input logic [31:0] now);
    return slot_valid[idx] && (slot_expiry[idx] == 32'd0 || slot_expiry[idx] >= now);
  endfunction

  // Applies one request to the table copy and returns the response the block owes.
  task automatic predict_response(input logic [2:0] op, input logic [31:0] now,
                                  input logic [31:0] k, input logic [31:0] v,
                                  input logic [31:0] life, output response_t resp);
    int          hit;
    int          spare;
    logic [32:0] sum;
    logic [31:0] expiry;
    hit         = -1;
    spare       = -1;
    resp.status = ttl_pkg::ST_MISSING;
    resp.value  = 32'd0;
    // Lowest live match wins; with time going backwards there may be several.
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit < 0 && is_live(i, now) && slot_key[i] == k) hit = i;
    end
    case (op)
      ttl_pkg::OP_GET: begin
        if (hit >= 0) begin
          resp.status = ttl_pkg::ST_FOUND;
          resp.value  = slot_value[hit];
        end
      end
      ttl_pkg::OP_SET: begin
        // Expiry is time + ttl - 1, saturated; a ttl of zero or less never expires.
        expiry = 32'd0;
        if (!life[31] && life != 32'd0) begin
          sum    = {1'b0, now} + {1'b0, life} - 33'd1;
          expiry = sum[32] ? TIME_MAX : sum[31:0];
        end
        if (hit < 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (spare < 0 && !is_live(i, now)) spare = i;
          end
          hit = spare;
        end
        if (hit < 0) begin
          resp.status = ttl_pkg::ST_FULL;
        end else begin
          slot_valid[hit]  = 1'b1;
          slot_key[hit]    = k;
          slot_value[hit]  = v;
          slot_expiry[hit] = expiry;
          resp.status      = ttl_pkg::ST_DONE;
          resp.value       = v;
        end
      end
      ttl_pkg::OP_DEL: begin
        if (hit >= 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (is_live(i, now) && slot_key[i] == k) slot_valid[i] = 1'b0;
          end
          resp.status = ttl_pkg::ST_DONE;
        end
      end
      ttl_pkg::OP_INC, ttl_pkg::OP_DEC: begin
        if (hit >= 0) begin
          slot_value[hit] = (op == ttl_pkg::OP_INC) ? slot_value[hit] + v
                                                    : slot_value[hit] - v;
          resp.status     = ttl_pkg::ST_FOUND;
          resp.value      = slot_value[hit];
        end
      end
      default: ;
    endcase
  endtask

  // Presents one request beat, holds it until accepted, then predicts its response.
  // Unless an idle gap follows, the valid is left high so back-to-back beats need no reassignment.
  task automatic send_request(input logic [2:0] op, input logic [31:0] now,
                              input logic [31:0] k, input logic [31:0] v,
                              input logic [31:0] life);
    response_t resp;
    operation      <= op;
    current_time   <= now;
    key            <= k;
    value_or_delta <= v;
    ttl            <= life;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_response(op, now, k, v, life, resp);
    awaited_responses.push_back(resp);
    status_tally[resp.status]++;
    requests_sent++;
    // Re-pick the sender's idling habit now and then, including stretches with none.
    if (requests_sent % 64 == 0) begin
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 10;
        default: gap_odds = 40;
      endcase
    end
    if (!calm && $urandom_range(0, 99) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Moves the request clock: mostly small steps, sometimes long jumps, rarely a
  // jump to anywhere (which may go backwards) or to just below the top of time.
  task automatic advance_clock(input int unsigned max_step);
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (dice < 82)      sim_now = sim_now + $urandom_range(0, max_step);
    else if (dice < 93) sim_now = sim_now + $urandom_range(max_step + 1, 400);
    else if (dice < 97) sim_now = $urandom;
    else                sim_now = TIME_MAX - $urandom_range(0, 255);
  endtask

  function automatic logic [31:0] pick_ttl();
    case ($urandom_range(0, 9))
      0, 1:    return 32'd0;
      2:       return {1'b1, 31'($urandom)};
      3:       return $urandom;
      4:       return INT_MAX;
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  function automatic logic [2:0] pick_operation();
    int unsigned dice;
    dice = $urandom_range(0, 99);
    if (dice < 35)      return ttl_pkg::OP_SET;
    else if (dice < 60) return ttl_pkg::OP_GET;
    else if (dice < 72) return ttl_pkg::OP_INC;
    else if (dice < 84) return ttl_pkg::OP_DEC;
    else if (dice < 96) return ttl_pkg::OP_DEL;
    else                return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
  endfunction

  // Every operation, the field extremes, the expiry corner cases and time
  // running backwards after an expired slot has been reused.
  task automatic test_directed();
    send_request(ttl_pkg::OP_SET, 32'd0, INT_MAX, INT_MIN, 32'd0);
    send_request(ttl_pkg::OP_GET, 32'd0, INT_MAX, 32'd0, 32'd0);
    send_request(ttl_pkg::OP_INC, 32'd1, INT_MAX, 32'hFFFF_FFFF, 32'd0);
    send_request(ttl_pkg::OP_DEC, 32'd2, INT_MAX, INT_MIN, INT_MAX);
    send_request(ttl_pkg::OP_DEL, 32'd3, INT_MAX, 32'd0, 32'd0);
    send_request(ttl_pkg::OP_GET, 32'd3, INT_MAX, 32'd0, 32'd0);
    send_request(ttl_pkg::OP_INC, 32'd4, INT_MAX, 32'd5, 32'd0);
    send_request(ttl_pkg::OP_DEC, 32'd4, INT_MAX, 32'd5, 32'd0);
    send_request(ttl_pkg::OP_DEL, 32'd5, INT_MAX, 32'd0, 32'd0);
    send_request(OP_SPARE_LO, 32'd5, INT_MAX, INT_MAX, INT_MAX);
    send_request(OP_SPARE_HI, 32'd5, INT_MIN, INT_MIN, INT_MIN);
    // A ttl of one at time zero computes to expiry zero, which means forever.
    send_request(ttl_pkg::OP_SET, 32'd0, INT_MIN, 32'd11, 32'd1);
    send_request(ttl_pkg::OP_SET, 32'd100, 32'd1, 32'd22, 32'd5);
    send_request(ttl_pkg::OP_GET, 32'd104, 32'd1, 32'd0, 32'd0);
    send_request(ttl_pkg::OP_GET, 32'd105, 32'd1, 32'd0, 32'd0);
    send_request(ttl_pkg::OP_GET, TIME_MAX, INT_MIN, 32'd0, 32'd0);
    // Expiry saturates at the top of the time range.
    send_request(ttl_pkg::OP_SET, 32'hFFFF_0000, 32'd2, 32'd33, INT_MAX);
    send_request(ttl_pkg::OP_GET, TIME_MAX, 32'd2, 32'd0, 32'd0);
    send_request(ttl_pkg::OP_SET, TIME_MAX, 32'd3, 32'hFFFF_FFFF, INT_MIN);
    // Time goes backwards, but key 2 already took key 1's expired slot.
    send_request(ttl_pkg::OP_GET, 32'd50, 32'd1, 32'd0, 32'd0);
    send_request(ttl_pkg::OP_SET, 32'd200, 32'd1, 32'd7, 32'd0);
    send_request(ttl_pkg::OP_GET, 32'd60, 32'd1, 32'd0, 32'd0);
    send_request(ttl_pkg::OP_DEL, 32'd60, 32'd1, 32'd0, 32'd0);
    send_request(ttl_pkg::OP_GET, 32'd60, 32'd1, 32'd0, 32'd0);
  endtask

  // General mixed traffic over a key pool slightly larger than the table.
  task automatic test_random_traffic(input int unsigned count);
    logic [31:0] k;
    for (int n = 0; n < count; n++) begin
      advance_clock(4);
      k = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, 19)] : $urandom;
      send_request(pick_operation(), sim_now, k, $urandom, pick_ttl());
    end
  endtask

  // Many distinct long-lived keys so the table fills up and sets come back full,
  // with deletes freeing slots again.
  task automatic test_table_pressure(input int unsigned count);
    int unsigned dice;
    logic [2:0]  op;
    for (int n = 0; n < count; n++) begin
      dice = $urandom_range(0, 99);
      if (dice < 65)      op = ttl_pkg::OP_SET;
      else if (dice < 82) op = ttl_pkg::OP_DEL;
      else if (dice < 92) op = ttl_pkg::OP_GET;
      else                op = ttl_pkg::OP_INC;
      sim_now = sim_now + $urandom_range(0, 1);
      send_request(op, sim_now, key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)], $urandom,
                   ($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 2000)) : 32'd0);
    end
  endtask

  // Short lifetimes and fast time so entries expire and slots are reused;
  // the sides run without idling here.
  task automatic test_expiry_churn(input int unsigned count);
    logic [31:0] life;
    for (int n = 0; n < count; n++) begin
      advance_clock(6);
      life = ($urandom_range(0, 9) == 0) ? pick_ttl() : 32'($urandom_range(1, 8));
      send_request(pick_operation(), sim_now, key_pool[$urandom_range(0, 11)], $urandom,
                   life);
    end
  endtask

  // Consumer side: stall in random bursts between free-running
  // stretches, and never once the run is calm.
  initial begin
    int unsigned run_left;
    bit          hold;
    run_left = 0;
    hold     = 1'b0;
    forever begin
      @(posedge clk);
      if (run_left == 0) begin
        if ($urandom_range(0, 2) == 0) begin
          hold     = 1'b1;
          run_left = $urandom_range(1, 18);
        end else begin
          hold     = 1'b0;
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40);
        end
      end
      out_stall <= hold && !calm && !rst;
      run_left--;
    end
  end

  // Response checker: every accepted result beat is matched against the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (awaited_responses.size() == 0) begin
        report_mismatch($sformatf("response with none awaited: status %0d value %0h",
                                  status, value));
      end else begin
        oldest_response = awaited_responses.pop_front();
        if (status !== oldest_response.status)
          report_mismatch($sformatf("status %0d, awaited %0d", status,
                                    oldest_response.status));
        else if (value !== oldest_response.value)
          report_mismatch($sformatf("value %0h, awaited %0h (status %0d)", value,
                                    oldest_response.value, status));
        else
          responses_ok++;
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_valid[i]  = 1'b0;
      slot_key[i]    = 32'd0;
      slot_value[i]  = 32'd0;
      slot_expiry[i] = 32'd0;
    end
    for (int i = 0; i < 4; i++) status_tally[i] = 0;
    // The pool holds the key extremes plus random keys.
    key_pool[0] = INT_MIN;
    key_pool[1] = INT_MAX;
    key_pool[2] = 32'd0;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    // Reset once; the block then clears its table before it takes a request.
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    sim_now = 32'd1000;
    test_random_traffic(900);
    test_table_pressure(450);
    calm = 1'b1;
    test_expiry_churn(300);

    in_valid <= 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    // Let any stray late beat show up before the verdict.
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    $display("Sent %0d requests, %0d responses matched, %0d mismatches.",
             requests_sent, responses_ok, mismatches);
    $display("Outcomes: %0d found, %0d missing, %0d stored or deleted, %0d table full.",
             status_tally[ttl_pkg::ST_FOUND], status_tally[ttl_pkg::ST_MISSING],
             status_tally[ttl_pkg::ST_DONE], status_tally[ttl_pkg::ST_FULL]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
